// File: design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and helpers for the stream find/replace block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int ADDR_W      = 5;
	localparam int LEN_W       = 4;
	localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
	localparam int POS_W       = $clog2(PATTERN_MAX);
	localparam int RCNT_W      = $clog2(REPLACE_MAX + 1);
	localparam int RPOS_W      = $clog2(REPLACE_MAX);

	typedef logic [BYTE_W-1:0] byte_t;

	// register map, one 64-bit slot per register
	typedef enum logic [1:0] {
		REG_SEARCH_PATTERN  = 2'd0,
		REG_SEARCH_LENGTH   = 2'd1,
		REG_REPLACE_PATTERN = 2'd2,
		REG_REPLACE_LENGTH  = 2'd3
	} reg_idx_t;

	// one unit of output work: replacement run, then window bytes
	// (read from byte_pos downward), then an optional end marker
	typedef struct packed {
		logic [RCNT_W-1:0]            rep_cnt;
		logic [CNT_W-1:0]             byte_cnt;
		logic [POS_W-1:0]             byte_pos;
		logic                         end_mark;
		byte_t [PATTERN_MAX-1:0]      snap;
	} job_t;

	function automatic logic [CNT_W-1:0] clamp_slen(input logic [LEN_W-1:0] v);
		if (v > LEN_W'(PATTERN_MAX))
			return CNT_W'(PATTERN_MAX);
		return CNT_W'(v);
	endfunction

	function automatic logic [RCNT_W-1:0] clamp_rlen(input logic [LEN_W-1:0] v);
		if (v > LEN_W'(REPLACE_MAX))
			return RCNT_W'(REPLACE_MAX);
		return RCNT_W'(v);
	endfunction

endpackage

// File: design/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window cell: holds a byte, compares it with its pattern byte, hands it to the next cell on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_cell import sfr_pkg::*; (
	input  logic  clk,
	input  logic  shift,
	input  byte_t byte_in,
	input  byte_t pat_byte,
	output byte_t byte_q,
	output logic  eq
);

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign eq = (byte_q == pat_byte);

endmodule

// File: design/sfr_emit.sv
// ----------------------------------------------------------------------------
// sfr_emit
// Output sequencer: plays one job out as a run of result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_emit import sfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  job_t                   job_in,
	input  logic [CFG_W-1:0]       replace_pattern,
	input  logic                   out_ready,
	output logic                   out_valid,
	output byte_t                  out_byte,
	output logic                   byte_valid,
	output logic                   result_end,
	output logic                   run_last,
	output logic                   slot_free
);

	logic              valid_q;
	job_t              job_q;
	logic [RPOS_W-1:0] rep_idx_q;

	logic rep_act;
	logic byte_act;
	logic take;

	assign rep_act  = (job_q.rep_cnt != '0);
	assign byte_act = (job_q.byte_cnt != '0);
	assign take     = valid_q && out_ready;

	always_comb begin
		if (rep_act) begin
			out_byte = replace_pattern[rep_idx_q*BYTE_W +: BYTE_W];
			run_last = (job_q.rep_cnt == RCNT_W'(1)) && !byte_act && !job_q.end_mark;
		end else if (byte_act) begin
			out_byte = job_q.snap[job_q.byte_pos];
			run_last = (job_q.byte_cnt == CNT_W'(1)) && !job_q.end_mark;
		end else begin
			out_byte = '0;
			run_last = 1'b1;
		end
	end

	assign out_valid  = valid_q;
	assign byte_valid = rep_act || byte_act;
	assign result_end = !rep_act && !byte_act;
	assign slot_free  = !valid_q || (out_ready && run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= 1'b0;
			job_q.rep_cnt  <= '0;
			job_q.byte_cnt <= '0;
			job_q.end_mark <= 1'b0;
			rep_idx_q      <= '0;
		end else if (load) begin
			valid_q   <= 1'b1;
			job_q     <= job_in;
			rep_idx_q <= '0;
		end else if (take) begin
			if (run_last) begin
				valid_q <= 1'b0;
			end
			if (rep_act) begin
				job_q.rep_cnt <= job_q.rep_cnt - RCNT_W'(1);
				rep_idx_q     <= rep_idx_q + RPOS_W'(1);
			end else if (byte_act) begin
				job_q.byte_cnt <= job_q.byte_cnt - CNT_W'(1);
				job_q.byte_pos <= job_q.byte_pos - POS_W'(1);
			end else begin
				job_q.end_mark <= 1'b0;
			end
		end
	end

endmodule

// File: design/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Path: accepted byte -> hold register -> sfr_emit job register -> result.
// Throughput: one byte per cycle while out_ready holds high and each byte
//   yields at most one result; n results hold the sequencer for n beats.
// Reset: arst_n clears config registers, window fill and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Streaming find-and-replace over a byte string.
//
// Data path:
//   in beat -> hold register -> window chain (PATTERN_MAX cells) -> job
//   register in sfr_emit -> result beats.
//
// The window is a shift chain: cell 0 holds the newest byte, cell k the byte
// seen k items earlier. Every byte that leaves the hold register shifts the
// chain by one. fill_q counts how many of the newest cells belong to
// the live window, so the oldest live byte sits at cell fill-1.
//
// Matching: when the incoming byte completes a window of search_length
// bytes, the incoming byte is compared against the last pattern byte and
// each cell j against pattern byte slen-2-j, all in parallel.
//
// Each item turns into one job: a replacement run, a run of window bytes
// taken from a snapshot of the chain, and an end marker on string end.
// The snapshot frees the chain for the next byte at once. An item that
// yields nothing (match deleted, or window still filling) passes the hold
// register without waiting for the sequencer.
//
// Config registers sit at byte addresses 0, 8, 16, 24 (64-bit slots).
// Writing search_length empties the window.

module stream_find_replace import sfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	// input beats
	input  logic              in_valid,
	output logic              in_ready,
	input  byte_t             data_byte,
	input  logic              string_end,

	// result beats
	output logic              out_valid,
	input  logic              out_ready,
	output byte_t             out_byte,
	output logic              byte_valid,
	output logic              result_end,
	output logic              run_last,

	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	// ---------------- config registers ----------------
	logic [CFG_W-1:0] search_pattern_q;
	logic [LEN_W-1:0] search_length_q;
	logic [CFG_W-1:0] replace_pattern_q;
	logic [LEN_W-1:0] replace_length_q;

	reg_idx_t         reg_idx;
	logic             cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_pattern_q  <= '0;
			search_length_q   <= '0;
			replace_pattern_q <= '0;
			replace_length_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SEARCH_PATTERN:  search_pattern_q  <= pwdata;
				REG_SEARCH_LENGTH:   search_length_q   <= pwdata[LEN_W-1:0];
				REG_REPLACE_PATTERN: replace_pattern_q <= pwdata;
				REG_REPLACE_LENGTH:  replace_length_q  <= pwdata[LEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SEARCH_PATTERN:  prdata = search_pattern_q;
			REG_SEARCH_LENGTH:   prdata = CFG_W'(search_length_q);
			REG_REPLACE_PATTERN: prdata = replace_pattern_q;
			REG_REPLACE_LENGTH:  prdata = CFG_W'(replace_length_q);
		endcase
	end

	logic [CNT_W-1:0]  slen;
	logic [RCNT_W-1:0] rlen;

	assign slen = clamp_slen(search_length_q);
	assign rlen = clamp_rlen(replace_length_q);

	// ---------------- hold register (input skid) ----------------
	logic  hold_valid_q;
	byte_t hold_byte_s1;
	logic  hold_end_s1;
	logic  advance;

	assign in_ready = !hold_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_valid_q <= 1'b1;
		end else if (advance) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_byte_s1 <= data_byte;
			hold_end_s1  <= string_end;
		end
	end

	// ---------------- window chain ----------------
	byte_t [PATTERN_MAX-1:0] cell_byte;
	logic  [PATTERN_MAX-1:0] cell_eq;
	logic  [PATTERN_MAX-1:0] cell_use;
	byte_t [PATTERN_MAX-1:0] cell_pat;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [CNT_W-1:0] pidx;
		byte_t            cin;

		assign pidx        = slen - CNT_W'(j) - CNT_W'(2);
		assign cell_pat[j] = search_pattern_q[pidx[POS_W-1:0]*BYTE_W +: BYTE_W];
		assign cell_use[j] = (CNT_W'(j) + CNT_W'(1)) < slen;

		if (j == 0) begin : g_head
			assign cin = hold_byte_s1;
		end else begin : g_link
			assign cin = cell_byte[j-1];
		end

		sfr_cell u_cell (
			.clk      (clk),
			.shift    (advance),
			.byte_in  (cin),
			.pat_byte (cell_pat[j]),
			.byte_q   (cell_byte[j]),
			.eq       (cell_eq[j])
		);
	end

	// ---------------- window control ----------------
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_base;
	logic [CNT_W-1:0] fill_inc;
	logic [CNT_W-1:0] slen_m1;
	logic [CNT_W-1:0] fill_nxt;
	logic             full;
	logic             hit;
	byte_t            last_pat;
	job_t             job;
	logic             job_busy;
	logic             slot_free;
	logic             load;

	assign slen_m1   = slen - CNT_W'(1);
	assign fill_base = (fill_q >= slen) ? '0 : fill_q;
	assign fill_inc  = fill_base + CNT_W'(1);
	assign full      = (slen != '0) && (fill_inc == slen);
	assign last_pat  = search_pattern_q[slen_m1[POS_W-1:0]*BYTE_W +: BYTE_W];
	assign hit       = (hold_byte_s1 == last_pat) && (&(cell_eq | ~cell_use));

	always_comb begin
		job.snap[0] = hold_byte_s1;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			job.snap[k] = cell_byte[k-1];
		end
		job.end_mark = hold_end_s1;
		job.rep_cnt  = '0;
		job.byte_cnt = '0;
		job.byte_pos = '0;
		fill_nxt     = '0;

		priority if (slen == '0) begin
			// pass through
			job.byte_cnt = CNT_W'(1);
		end else if (full && hit) begin
			job.rep_cnt = rlen;
		end else if (full) begin
			// oldest byte out; on string end the rest follows
			job.byte_pos = slen_m1[POS_W-1:0];
			job.byte_cnt = hold_end_s1 ? slen : CNT_W'(1);
			fill_nxt     = hold_end_s1 ? '0 : slen_m1;
		end else begin
			// still filling: flush only on string end
			job.byte_pos = fill_base[POS_W-1:0];
			job.byte_cnt = hold_end_s1 ? fill_inc : '0;
			fill_nxt     = hold_end_s1 ? '0 : fill_inc;
		end
	end

	assign job_busy = (job.rep_cnt != '0) || (job.byte_cnt != '0) || job.end_mark;
	assign advance  = hold_valid_q && (slot_free || !job_busy);
	assign load     = advance && job_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_wr && (reg_idx == REG_SEARCH_LENGTH)) begin
			fill_q <= '0;
		end else if (advance) begin
			fill_q <= fill_nxt;
		end
	end

	// ---------------- output sequencer ----------------
	sfr_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.job_in          (job),
		.replace_pattern (replace_pattern_q),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.out_byte        (out_byte),
		.byte_valid      (byte_valid),
		.result_end      (result_end),
		.run_last        (run_last),
		.slot_free       (slot_free)
	);

endmodule

// File: design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for stream_find_replace, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input byte_t out_byte,
	input logic  byte_valid,
	input logic  result_end,
	input logic  run_last
);

	// a stalled result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(byte_valid) && $stable(result_end) && $stable(run_last))
		else $error("result beat changed while stalled");

	// an end marker is a bare beat that closes its run
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_end |-> run_last && !byte_valid && (out_byte == '0))
		else $error("malformed end marker");

	// every beat carries either a byte or the end marker
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_valid != result_end)
		else $error("beat is neither byte nor end marker");

	// input side only backs up behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
